[sv/btc_pkg.sv]
// Shared types, constants and the opcode length table for the branch target collector.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package btc_pkg;

	localparam int unsigned LABEL_SLOTS_DEF = 2048;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

	localparam logic REQ_FEED = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  code_byte;
		logic [10:0] read_index;
	} req_t;

	typedef struct packed {
		logic        instr_start;
		logic [15:0] instr_address;
		logic [1:0]  instr_length;
		logic        label_added;
		logic        label_known;
		logic        table_full;
		logic [11:0] label_count;
		logic [15:0] read_value;
		logic        read_valid;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_PASS,
		OP_INSERT,
		OP_READ
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic        instr_start;
		logic [15:0] instr_address;
		logic [1:0]  instr_length;
		logic [15:0] value;
		logic [10:0] read_index;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_COMPARE,
		BK_SHIFT_RD,
		BK_SHIFT_WR,
		BK_PLACE,
		BK_READ,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic added;
		logic known;
		logic full;
	} label_flags_t;

	// Instruction length of each 8085 opcode; CNZ (C4h) is not listed and gets a length of one.
	function automatic logic [1:0] size_of(input logic [7:0] opcode);
		logic [1:0] len;
		case (opcode)
			8'h01, 8'h11, 8'h21, 8'h31, 8'h22, 8'h32, 8'h2A, 8'h3A,
			8'hC2, 8'hC3, 8'hCA, 8'hCC, 8'hCD,
			8'hD2, 8'hD4, 8'hDA, 8'hDC,
			8'hE2, 8'hE4, 8'hEA, 8'hEC,
			8'hF2, 8'hF4, 8'hFA, 8'hFC: len = 2'd3;
			8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
			8'hC6, 8'hCE, 8'hD3, 8'hD6, 8'hDB, 8'hDE,
			8'hE6, 8'hEE, 8'hF6, 8'hFE: len = 2'd2;
			default: len = 2'd1;
		endcase
		return len;
	endfunction

endpackage

[sv/btc_stream_if.sv]
// Valid/ready channel carrying one payload per beat.
// The payload type is set per instance; depends on nothing.
`timescale 1ns / 1ps

interface btc_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/btc_front.sv]
// Front end: decodes opcode lengths, tracks the instruction address and turns each
// request into a command for the table engine. Depends on btc_pkg and btc_stream_if.
`timescale 1ns / 1ps

module btc_front (
	input logic          clk,
	input logic          arst_n,
	btc_stream_if.sink   req,
	btc_stream_if.source cmd
);
	import btc_pkg::*;

	logic [1:0]  rem_q, rem_d;
	logic [7:0]  low_q, low_d;
	logic [1:0]  len_q, len_d;
	logic [15:0] ip_q, ip_d;
	logic [1:0]  op_len;
	logic        accept;
	cmd_t        cmd_d;

	assign op_len = size_of(req.data.code_byte);
	assign accept = req.valid && req.ready;

	always_comb begin
		rem_d = rem_q;
		low_d = low_q;
		len_d = len_q;
		ip_d = ip_q;
		cmd_d.op = OP_PASS;
		cmd_d.instr_start = 1'b0;
		cmd_d.instr_address = 16'h0000;
		cmd_d.instr_length = 2'd1;
		cmd_d.value = {req.data.code_byte, low_q};
		cmd_d.read_index = req.data.read_index;
		if (req.data.req_type == REQ_READ) begin
			cmd_d.op = OP_READ;
		end else if (rem_q == 2'd0) begin
			cmd_d.instr_start = 1'b1;
			cmd_d.instr_address = ip_q;
			cmd_d.instr_length = op_len;
			ip_d = ip_q + 16'(op_len);
			rem_d = op_len - 2'd1;
			len_d = op_len;
		end else begin
			cmd_d.instr_address = ip_q - 16'(len_q);
			cmd_d.instr_length = len_q;
			if (rem_q >= 2'd2) begin
				low_d = req.data.code_byte;
			end else if (len_q == 2'd3) begin
				cmd_d.op = OP_INSERT;
			end
			rem_d = rem_q - 2'd1;
		end
	end

	assign cmd.valid = req.valid;
	assign cmd.data = cmd_d;
	assign req.ready = cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			low_q <= 8'h00;
			len_q <= 2'd1;
			ip_q <= 16'h0000;
		end else if (accept) begin
			rem_q <= rem_d;
			low_q <= low_d;
			len_q <= len_d;
			ip_q <= ip_d;
		end
	end

endmodule

[sv/btc_queue.sv]
// Short command queue between the front end and the table engine.
// Depends on btc_pkg and btc_stream_if.
`timescale 1ns / 1ps

module btc_queue (
	input logic          clk,
	input logic          arst_n,
	btc_stream_if.sink   push,
	btc_stream_if.source pop
);
	import btc_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push.ready = (fill_q != NW'(QUEUE_DEPTH));
	assign pop.valid = (fill_q != '0);
	assign pop.data = slot_q[rd_q];
	assign do_push = push.valid && push.ready;
	assign do_pop = pop.valid && pop.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[sv/btc_back.sv]
// Table engine: keeps the sorted label memory, performs binary search, shift and insert,
// serves read requests and holds the result register. Depends on btc_pkg and btc_stream_if.
`timescale 1ns / 1ps

module btc_back #(
	parameter int unsigned LABEL_SLOTS = btc_pkg::LABEL_SLOTS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	btc_stream_if.sink   cmd,
	btc_stream_if.source rsp
);
	import btc_pkg::*;

	localparam int unsigned AW = $clog2(LABEL_SLOTS);
	localparam int unsigned CW = $clog2(LABEL_SLOTS + 1);

	logic [15:0]   mem [LABEL_SLOTS];
	logic [15:0]   rdata_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          we;

	bk_state_t     state_q, state_d;
	cmd_t          cmd_q;
	label_flags_t  flags_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] mid_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] j_less;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic          is_full;
	logic          load_out;
	logic          rd_hit;
	logic          out_valid_q;
	rsp_t          out_q;
	rsp_t          out_d;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CW:1];
	assign j_less = j_q - 1'b1;
	assign is_full = (total_q >= CW'(LABEL_SLOTS));
	assign rd_hit = (cmd_q.op == OP_READ) && (32'(cmd_q.read_index) < 32'(total_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd.valid) begin
					case (cmd.data.op)
						OP_READ: state_d = BK_READ;
						OP_INSERT: begin
							state_d = (cmd.data.value == EMPTY_MARK) ? BK_DONE : BK_SEARCH;
						end
						default: state_d = BK_DONE;
					endcase
				end
			end
			BK_SEARCH: begin
				if (lo_q != hi_q) begin
					state_d = BK_COMPARE;
				end else if (is_full) begin
					state_d = BK_DONE;
				end else if (total_q > lo_q) begin
					state_d = BK_SHIFT_RD;
				end else begin
					state_d = BK_PLACE;
				end
			end
			BK_COMPARE: begin
				state_d = (rdata_q == cmd_q.value) ? BK_DONE : BK_SEARCH;
			end
			BK_SHIFT_RD: state_d = BK_SHIFT_WR;
			BK_SHIFT_WR: state_d = (j_less == lo_q) ? BK_PLACE : BK_SHIFT_RD;
			BK_PLACE: state_d = BK_DONE;
			BK_READ: state_d = BK_DONE;
			BK_DONE: begin
				if (load_out) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		raddr = AW'(cmd_q.read_index);
		waddr = j_q[AW-1:0];
		wdata = rdata_q;
		we = 1'b0;
		case (state_q)
			BK_SEARCH: raddr = mid[AW-1:0];
			BK_SHIFT_RD: raddr = j_less[AW-1:0];
			BK_SHIFT_WR: we = 1'b1;
			BK_PLACE: begin
				we = 1'b1;
				waddr = lo_q[AW-1:0];
				wdata = cmd_q.value;
			end
			default: we = 1'b0;
		endcase
	end

	assign cmd.ready = (state_q == BK_IDLE);
	assign load_out = (state_q == BK_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		out_d.instr_start = cmd_q.instr_start;
		out_d.instr_address = cmd_q.instr_address;
		out_d.instr_length = cmd_q.instr_length;
		out_d.label_added = flags_q.added;
		out_d.label_known = flags_q.known;
		out_d.table_full = flags_q.full;
		out_d.label_count = 12'(total_q);
		out_d.read_value = rd_hit ? rdata_q : EMPTY_MARK;
		out_d.read_valid = rd_hit;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (cmd.valid) begin
					cmd_q <= cmd.data;
					flags_q <= '{added: 1'b0, full: 1'b0,
						known: (cmd.data.op == OP_INSERT) && (cmd.data.value == EMPTY_MARK)};
					lo_q <= '0;
					hi_q <= total_q;
				end
			end
			BK_SEARCH: begin
				mid_q <= mid;
				if (lo_q == hi_q) begin
					j_q <= total_q;
					flags_q.full <= is_full;
				end
			end
			BK_COMPARE: begin
				if (rdata_q == cmd_q.value) begin
					flags_q.known <= 1'b1;
				end else if (rdata_q < cmd_q.value) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			BK_SHIFT_WR: j_q <= j_less;
			BK_PLACE: flags_q.added <= 1'b1;
			default: j_q <= j_q;
		endcase
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_PLACE) begin
				total_q <= total_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

endmodule

[sv/i8085_branch_target_collector.sv]
// Top level of the 8085 branch target collector: front end, command queue and table engine.
// Depends on btc_pkg, btc_stream_if, btc_front, btc_queue and btc_back.
`timescale 1ns / 1ps

// The front end takes one request beat per cycle while the four-entry command queue has room;
// the table engine takes one command at a time. A label insert runs a binary search and, unless
// the label is found or the table is full, moves each stored label above it up by a read and a
// write, since the label memory has one read and one write port, and then places it. Result
// beats wait in an output register; while the sink stalls, the engine holds its finished command
// and the queue fills, after which the request side stalls as well. There is no clearing pass
// after reset: only the first label_count entries of the memory are ever read.
module i8085_branch_target_collector #(
	parameter int unsigned LABEL_SLOTS = btc_pkg::LABEL_SLOTS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	btc_stream_if.sink   req,
	btc_stream_if.source rsp
);
	import btc_pkg::*;

	btc_stream_if #(.data_t(cmd_t)) front_q ();
	btc_stream_if #(.data_t(cmd_t)) q_back ();

	btc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (front_q)
	);

	btc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_q),
		.pop    (q_back)
	);

	btc_back #(
		.LABEL_SLOTS (LABEL_SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (q_back),
		.rsp    (rsp)
	);

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0({rsp.data.label_added, rsp.data.label_known,
			rsp.data.table_full}))
		else $error("More than one label outcome in one result beat.");

	a_no_empty_mark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.read_valid |-> rsp.data.read_value != EMPTY_MARK)
		else $error("A stored label reads back as the empty marker.");

	a_insert_on_operand: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.label_added |->
			!rsp.data.instr_start && rsp.data.instr_length == 2'd3)
		else $error("Label inserted outside the last byte of a three-byte instruction.");

endmodule
